@@ rtl/wait_for_chain_deadlock_detector_macros.svh @@
// assertion helpers for the detector rtl
`ifndef WAIT_FOR_CHAIN_DEADLOCK_DETECTOR_MACROS_SVH
`define WAIT_FOR_CHAIN_DEADLOCK_DETECTOR_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define WFCDD_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored while reset is high
`define WFCDD_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wfcdd_pkg.sv @@
package wfcdd_pkg;

  localparam int NUM_PROCS_DEF = 16;
  localparam int NUM_LOCKS_DEF = 16;

  localparam int OPCODE_W = 2;
  localparam int ID_W     = 4;
  localparam int STEPS_W  = 5;
  localparam int STATUS_W = 2;

  // event opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_REQUEST = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2
  } opcode_t;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_OWNER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LIMIT    = 2'd2;

  // microprogram addresses
  localparam int UPC_W = 3;
  typedef enum logic [UPC_W-1:0] {
    U_IDLE,
    U_ACQUIRE,
    U_RELEASE,
    U_REQUEST,
    U_HOP_OWNER,
    U_HOP_WAIT,
    U_EMIT
  } upc_t;

  // datapath actions
  typedef enum logic [2:0] {
    A_NONE,
    A_TAKE,
    A_ACQUIRE,
    A_RELEASE,
    A_RECORD,
    A_HOP,
    A_FOLLOW,
    A_EMIT
  } act_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_UNOWNED,
    C_HOP_END,
    C_FOLLOW_END,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t  act;
    logic  own_rd_follow;
    cond_t cond;
    upc_t  jmp_true;
    upc_t  jmp_false;
  } uword_t;

  typedef struct packed {
    logic                accept;
    logic                bad;
    logic [OPCODE_W-1:0] opcode;
    logic                unowned;
    logic                hop_end;
    logic                follow_end;
    logic                out_busy;
  } flags_t;

  // control store
  function automatic uword_t ucode(input upc_t upc);
    uword_t w;
    w = '{act: A_NONE, own_rd_follow: 1'b0, cond: C_ALWAYS,
          jmp_true: U_IDLE, jmp_false: U_IDLE};
    unique case (upc)
      U_IDLE:      w = '{A_TAKE,    1'b0, C_DISPATCH,   U_IDLE,      U_IDLE};
      U_ACQUIRE:   w = '{A_ACQUIRE, 1'b0, C_ALWAYS,     U_EMIT,      U_EMIT};
      U_RELEASE:   w = '{A_RELEASE, 1'b0, C_ALWAYS,     U_EMIT,      U_EMIT};
      U_REQUEST:   w = '{A_RECORD,  1'b0, C_UNOWNED,    U_EMIT,      U_HOP_OWNER};
      U_HOP_OWNER: w = '{A_HOP,     1'b0, C_HOP_END,    U_EMIT,      U_HOP_WAIT};
      U_HOP_WAIT:  w = '{A_FOLLOW,  1'b1, C_FOLLOW_END, U_EMIT,      U_HOP_OWNER};
      U_EMIT:      w = '{A_EMIT,    1'b0, C_OUT_BUSY,   U_EMIT,      U_IDLE};
      default:     w = '{A_NONE,    1'b0, C_ALWAYS,     U_IDLE,      U_IDLE};
    endcase
    return w;
  endfunction

  // opcode dispatch out of idle
  function automatic upc_t dispatch(input flags_t f);
    upc_t t;
    t = U_IDLE;
    priority if (!f.accept)              t = U_IDLE;
    else if (f.bad)                      t = U_EMIT;
    else if (f.opcode == OP_REQUEST)     t = U_REQUEST;
    else if (f.opcode == OP_ACQUIRE)     t = U_ACQUIRE;
    else                                 t = U_RELEASE;
    return t;
  endfunction

endpackage

@@ rtl/wfcdd_evt_if.sv @@
interface wfcdd_evt_if
  import wfcdd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ID_W-1:0]     process_id;
  logic [ID_W-1:0]     lock_id;

  modport source (output valid, opcode, process_id, lock_id, input ready);
  modport sink (input valid, opcode, process_id, lock_id, output ready);
endinterface

@@ rtl/wfcdd_res_if.sv @@
interface wfcdd_res_if
  import wfcdd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                deadlock;
  logic [STEPS_W-1:0]  chain_steps;
  logic [STATUS_W-1:0] status;

  modport source (output valid, deadlock, chain_steps, status, input ready);
  modport sink (input valid, deadlock, chain_steps, status, output ready);
endinterface

@@ rtl/wfcdd_ram.sv @@
module wfcdd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/wfcdd_seq.sv @@
module wfcdd_seq
  import wfcdd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output uword_t uw
);
  upc_t upc;
  upc_t upc_next;
  logic cond_hit;

  always_comb begin
    uw = ucode(upc);
    unique case (uw.cond)
      C_ALWAYS:     cond_hit = 1'b1;
      C_DISPATCH:   cond_hit = 1'b1;
      C_UNOWNED:    cond_hit = flags.unowned;
      C_HOP_END:    cond_hit = flags.hop_end;
      C_FOLLOW_END: cond_hit = flags.follow_end;
      C_OUT_BUSY:   cond_hit = flags.out_busy;
      default:      cond_hit = 1'b1;
    endcase
    if (uw.cond == C_DISPATCH) begin
      upc_next = dispatch(flags);
    end else begin
      upc_next = cond_hit ? uw.jmp_true : uw.jmp_false;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end
endmodule

@@ rtl/wfcdd_dp.sv @@
module wfcdd_dp
  import wfcdd_pkg::*;
#(
  parameter int NUM_PROCS = NUM_PROCS_DEF,
  parameter int NUM_LOCKS = NUM_LOCKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  uword_t                             uw,
  input  logic                               accept,
  input  logic                               out_busy,
  input  logic [OPCODE_W-1:0]                opcode,
  input  logic [ID_W-1:0]                    process_id,
  input  logic [ID_W-1:0]                    lock_id,
  output flags_t                             flags,
  output logic                               dead,
  output logic [$clog2(NUM_PROCS+1)-1:0]     steps,
  output logic [STATUS_W-1:0]                status
);
  localparam int PW = $clog2(NUM_PROCS);
  localparam int LW = $clog2(NUM_LOCKS);
  localparam int SW = $clog2(NUM_PROCS + 1);

  logic [NUM_LOCKS-1:0] owner_valid;
  logic [NUM_PROCS-1:0] waiting_valid;
  logic [PW-1:0]        proc;
  logic [LW-1:0]        start;

  logic [PW-1:0] owner_rdata;
  logic [LW-1:0] wait_rdata;
  logic [LW-1:0] owner_raddr;
  logic          op_known;
  logic          limit;
  logic          closes;

  assign op_known = (opcode == OP_REQUEST) || (opcode == OP_ACQUIRE) ||
                    (opcode == OP_RELEASE);
  assign limit    = (steps == SW'(NUM_PROCS));
  assign closes   = (wait_rdata == start);

  assign owner_raddr = uw.own_rd_follow ? wait_rdata : start;

  always_comb begin
    flags.accept     = accept;
    flags.bad        = !op_known || (32'(process_id) >= NUM_PROCS) ||
                       (32'(lock_id) >= NUM_LOCKS);
    flags.opcode     = opcode;
    flags.unowned    = !owner_valid[start];
    flags.hop_end    = limit || !waiting_valid[owner_rdata];
    flags.follow_end = closes || !owner_valid[wait_rdata];
    flags.out_busy   = out_busy;
  end

  // lock -> owning process
  wfcdd_ram #(.WIDTH(PW), .DEPTH(NUM_LOCKS)) u_owner_ram (
    .clk   (clk),
    .we    (uw.act == A_ACQUIRE),
    .waddr (start),
    .wdata (proc),
    .raddr (owner_raddr),
    .rdata (owner_rdata)
  );

  // process -> lock it waits on
  wfcdd_ram #(.WIDTH(LW), .DEPTH(NUM_PROCS)) u_wait_ram (
    .clk   (clk),
    .we    (uw.act == A_RECORD),
    .waddr (proc),
    .wdata (start),
    .raddr (owner_rdata),
    .rdata (wait_rdata)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      owner_valid   <= '0;
      waiting_valid <= '0;
    end else begin
      unique case (uw.act)
        A_ACQUIRE: begin
          waiting_valid[proc] <= 1'b0;
          owner_valid[start]  <= 1'b1;
        end
        A_RELEASE: owner_valid[start]  <= 1'b0;
        A_RECORD:  waiting_valid[proc] <= 1'b1;
        A_NONE, A_TAKE, A_HOP, A_FOLLOW, A_EMIT: ;
      endcase
    end
  end

  // event fields and walk results
  always_ff @(posedge clk) begin
    unique case (uw.act)
      A_TAKE: begin
        if (accept) begin
          proc   <= PW'(process_id);
          start  <= LW'(lock_id);
          dead   <= 1'b0;
          steps  <= '0;
          status <= ST_OK;
        end
      end
      A_RECORD: begin
        if (!owner_valid[start]) begin
          status <= ST_NO_OWNER;
        end
      end
      A_HOP: begin
        if (limit) begin
          status <= ST_LIMIT;
        end else begin
          steps <= steps + SW'(1);
        end
      end
      A_FOLLOW: begin
        if (closes) begin
          dead <= 1'b1;
        end
      end
      A_NONE, A_ACQUIRE, A_RELEASE, A_EMIT: ;
    endcase
  end
endmodule

@@ rtl/wait_for_chain_deadlock_detector.sv @@
// events are taken one at a time: a new event is accepted only in the idle step, after the
//   previous result has been loaded into the result register
// a request walks lock -> owner -> waited lock through the registered owner and wait table
//   ports until the chain ends at an owner that does not wait, closes, meets a free lock,
//   starts at one, or reaches the walk limit of NUM_PROCS owner hops
// reset: synchronous, clears sequencer, result valid and valid bits; table contents kept
`include "wait_for_chain_deadlock_detector_macros.svh"

module wait_for_chain_deadlock_detector
  import wfcdd_pkg::*;
#(
  parameter int NUM_PROCS = NUM_PROCS_DEF,
  parameter int NUM_LOCKS = NUM_LOCKS_DEF
) (
  input logic          clk,
  input logic          rst,
  wfcdd_evt_if.sink    evt,
  wfcdd_res_if.source  res
);
  localparam int SW = $clog2(NUM_PROCS + 1);

  // sequencer <-> datapath
  uword_t uw;
  flags_t flags;

  logic                accept;
  logic                out_busy;
  logic                load;
  logic                dead;
  logic [SW-1:0]       steps;
  logic [STATUS_W-1:0] status;

  // result register, parts the walk from the output side
  logic                res_valid;
  logic                res_dead;
  logic [STEPS_W-1:0]  res_steps;
  logic [STATUS_W-1:0] res_status;

  // an event is taken only from the idle step of the program
  assign evt.ready = (uw.act == A_TAKE);
  assign accept    = evt.valid && evt.ready;

  // a pending result that is not taken this cycle holds the emit step
  assign out_busy = res_valid && !res.ready;
  assign load     = (uw.act == A_EMIT) && !out_busy;

  wfcdd_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uw    (uw)
  );

  // walk datapath: owner and wait tables, hop counter, verdict
  wfcdd_dp #(
    .NUM_PROCS (NUM_PROCS),
    .NUM_LOCKS (NUM_LOCKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .uw         (uw),
    .accept     (accept),
    .out_busy   (out_busy),
    .opcode     (evt.opcode),
    .process_id (evt.process_id),
    .lock_id    (evt.lock_id),
    .flags      (flags),
    .dead       (dead),
    .steps      (steps),
    .status     (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // hop count leaves masked to the result field width
  always_ff @(posedge clk) begin
    if (load) begin
      res_dead   <= dead;
      res_steps  <= STEPS_W'(steps);
      res_status <= status;
    end
  end

  assign res.valid       = res_valid;
  assign res.deadlock    = res_dead;
  assign res.chain_steps = res_steps;
  assign res.status      = res_status;

  // a closed cycle is never reported together with a failure status
  `WFCDD_ASSERT_SAME(a_dead_status_ok, clk, rst, res_valid && res_dead, res_status == ST_OK, "deadlock with bad status")
  // an unowned requested lock means no hop was walked
  `WFCDD_ASSERT_SAME(a_no_owner_no_hops, clk, rst, res_valid && (res_status == ST_NO_OWNER), (res_steps == '0) && !res_dead, "hops walked on unowned lock")
  // the walk never passes its hop limit
  `WFCDD_ASSERT_SAME(a_steps_bound, clk, rst, uw.act == A_HOP, steps <= SW'(NUM_PROCS), "hop counter past limit")
  // after a load the result is pending in the next cycle
  `WFCDD_ASSERT_NEXT(a_load_shows, clk, rst, load, res_valid, "loaded result not shown")
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import wfcdd_pkg::*;

  // opcode value outside the defined set, the block must ignore it
  localparam logic [OPCODE_W-1:0] OP_UNDEF = 2'd3;

  localparam int N_PROCS = NUM_PROCS_DEF;
  localparam int N_LOCKS = NUM_LOCKS_DEF;
  // worst request walk plus handshake overhead, used to drain the pipe at the end
  localparam int DRAIN_CYCLES = 2 * N_PROCS + 8;
  // longest legal quiet stretch is a send gap, a request walk and a receive stall, keep a wide margin
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_PHASES = 7;

  typedef struct packed {
    logic                deadlock;
    logic [STEPS_W-1:0]  chain_steps;
    logic [STATUS_W-1:0] status;
  } verdict_t;

  // one stimulus row; fixed_ok marks a row whose verdict is typed in by hand
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ID_W-1:0]     process_id;
    logic [ID_W-1:0]     lock_id;
    logic                fixed_ok;
    verdict_t            fixed;
  } event_row_t;

  logic clk;
  logic rst;

  wfcdd_evt_if evt_ch ();
  wfcdd_res_if res_ch ();

  wait_for_chain_deadlock_detector uut (
    .clk (clk),
    .rst (rst),
    .evt (evt_ch),
    .res (res_ch)
  );

  // shadow copy of the lock and wait tables
  logic              lock_held   [N_LOCKS];
  logic [ID_W-1:0]   lock_holder [N_LOCKS];
  logic              proc_blocked[N_PROCS];
  logic [ID_W-1:0]   proc_waits_on[N_PROCS];

  // verdicts still owed by the block, oldest first
  verdict_t pending_verdicts[$];

  int errors = 0;
  int n_events = 0;
  int n_requests = 0;
  int n_deadlocks = 0;
  int n_limit_hits = 0;
  int n_unowned = 0;
  int n_verdicts = 0;

  // idle bursts: each side flips between random gaps and back-to-back transactions
  logic send_burst = 1'b0;
  logic recv_burst = 1'b0;

  // clock, period 2 ns
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // reset held from time zero, released on a falling edge, never asserted again
  initial begin
    rst = 1'b1;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
  end

  // follow lock -> owner -> waited lock ... from the requested lock
  function automatic verdict_t walk_wait_chain(input logic [ID_W-1:0] start);
    verdict_t v;
    logic [ID_W-1:0] cur;
    logic [ID_W-1:0] holder;
    int hops;
    logic done;
    v = '0;
    cur = start;
    hops = 0;
    done = 1'b0;
    while (!done) begin
      if (!lock_held[cur]) begin
        // lock on the chain free: nothing to wait for; no owner only if it is the requested lock
        if (hops == 0) v.status = ST_NO_OWNER;
        done = 1'b1;
      end else if (hops >= N_PROCS) begin
        // looped without coming back to the requested lock
        v.status = ST_LIMIT;
        done = 1'b1;
      end else begin
        holder = lock_holder[cur];
        hops++;
        if (!proc_blocked[holder]) begin
          done = 1'b1;
        end else begin
          cur = proc_waits_on[holder];
          if (cur == start) begin
            v.deadlock = 1'b1;
            done = 1'b1;
          end
        end
      end
    end
    v.chain_steps = hops[STEPS_W-1:0];
    return v;
  endfunction

  // apply one accepted event to the shadow tables and return the verdict
  function automatic verdict_t apply_event(input event_row_t e);
    verdict_t v;
    v = '0;
    if (e.opcode == OP_REQUEST) begin
      proc_blocked[e.process_id] = 1'b1;
      proc_waits_on[e.process_id] = e.lock_id;
      v = walk_wait_chain(e.lock_id);
    end else if (e.opcode == OP_ACQUIRE) begin
      proc_blocked[e.process_id] = 1'b0;
      lock_held[e.lock_id] = 1'b1;
      lock_holder[e.lock_id] = e.process_id;
    end else if (e.opcode == OP_RELEASE) begin
      // freed even when the releasing process is not the owner
      lock_held[e.lock_id] = 1'b0;
    end
    return v;
  endfunction

  function automatic int draw_gap(input logic burst);
    if (burst) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [ID_W-1:0] pick_id(input int pool, input int base);
    int idx;
    idx = (base + $urandom_range(0, pool - 1)) % 16;
    return idx[ID_W-1:0];
  endfunction

  // mostly well-formed traffic over a small id pool so that chains get long
  function automatic event_row_t random_event(input int pool, input int base);
    event_row_t e;
    int r;
    int tries;
    e = '0;
    r = $urandom_range(0, 99);
    e.process_id = pick_id(pool, base);
    e.lock_id = pick_id(pool, base);
    if (r < 4) begin
      // noise, any opcode including the undefined one, any ids
      e.opcode = OPCODE_W'($urandom_range(0, 3));
      e.process_id = ID_W'($urandom_range(0, 15));
      e.lock_id = ID_W'($urandom_range(0, 15));
    end else if (r < 50) begin
      e.opcode = OP_REQUEST;
    end else if (r < 78) begin
      e.opcode = OP_ACQUIRE;
      // prefer a free lock, like a real grant would
      tries = 0;
      while (lock_held[e.lock_id] && tries < 4) begin
        e.lock_id = pick_id(pool, base);
        tries++;
      end
    end else begin
      e.opcode = OP_RELEASE;
      if (lock_held[e.lock_id] && $urandom_range(0, 4) != 0)
        e.process_id = lock_holder[e.lock_id];
    end
    return e;
  endfunction

  // drive one transaction on the event channel, called on a falling edge
  task automatic send_event(input event_row_t e);
    int gap;
    verdict_t v;
    if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      evt_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt_ch.valid <= 1'b1;
    evt_ch.opcode <= e.opcode;
    evt_ch.process_id <= e.process_id;
    evt_ch.lock_id <= e.lock_id;
    do @(posedge clk); while (!evt_ch.ready);
    // accepted on this edge: update shadow state and queue the verdict
    v = apply_event(e);
    pending_verdicts.push_back(e.fixed_ok ? e.fixed : v);
    n_events++;
    if (e.opcode == OP_REQUEST) begin
      n_requests++;
      if (v.deadlock) n_deadlocks++;
      if (v.status == ST_LIMIT) n_limit_hits++;
      if (v.status == ST_NO_OWNER) n_unowned++;
    end
    @(negedge clk);
  endtask

  // stop sending until every owed verdict has come back
  task automatic hold_until_drained();
    evt_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // directed rows: reset state, id extremes, every opcode, the special cases
  localparam int N_DIRECTED = 22;
  event_row_t directed_rows[N_DIRECTED] = '{
    // request on a free lock straight after reset
    '{OP_REQUEST, 4'd0,  4'd0,  1'b1, '{1'b0, 5'd0,  ST_NO_OWNER}},
    // release of a free lock keeps it free
    '{OP_RELEASE, 4'd15, 4'd15, 1'b1, '{1'b0, 5'd0,  ST_OK}},
    '{OP_ACQUIRE, 4'd15, 4'd15, 1'b1, '{1'b0, 5'd0,  ST_OK}},
    // undefined opcode is dropped
    '{OP_UNDEF,   4'd3,  4'd7,  1'b1, '{1'b0, 5'd0,  ST_OK}},
    '{OP_ACQUIRE, 4'd0,  4'd0,  1'b1, '{1'b0, 5'd0,  ST_OK}},
    // chain ends at an owner that is not waiting
    '{OP_REQUEST, 4'd0,  4'd15, 1'b1, '{1'b0, 5'd1,  ST_OK}},
    // two-party cycle closes
    '{OP_REQUEST, 4'd15, 4'd0,  1'b1, '{1'b1, 5'd2,  ST_OK}},
    '{OP_ACQUIRE, 4'd1,  4'd1,  1'b0, '0},
    '{OP_ACQUIRE, 4'd2,  4'd2,  1'b0, '0},
    '{OP_REQUEST, 4'd1,  4'd2,  1'b0, '0},
    '{OP_REQUEST, 4'd2,  4'd1,  1'b0, '0},
    '{OP_ACQUIRE, 4'd3,  4'd3,  1'b0, '0},
    '{OP_REQUEST, 4'd3,  4'd1,  1'b0, '0},
    // lock 3 leads into the wait loop of processes 1 and 2, which never returns to lock 3
    '{OP_REQUEST, 4'd4,  4'd3,  1'b1, '{1'b0, 5'd16, ST_LIMIT}},
    // release by a process that does not own the lock
    '{OP_RELEASE, 4'd9,  4'd1,  1'b1, '{1'b0, 5'd0,  ST_OK}},
    // chain now ends at the freed lock
    '{OP_REQUEST, 4'd4,  4'd3,  1'b0, '0},
    '{OP_ACQUIRE, 4'd2,  4'd1,  1'b0, '0},
    // owner waits on its own lock
    '{OP_REQUEST, 4'd15, 4'd15, 1'b0, '0},
    '{OP_UNDEF,   4'd15, 4'd15, 1'b1, '{1'b0, 5'd0,  ST_OK}},
    '{OP_RELEASE, 4'd15, 4'd15, 1'b1, '{1'b0, 5'd0,  ST_OK}},
    '{OP_REQUEST, 4'd5,  4'd15, 1'b1, '{1'b0, 5'd0,  ST_NO_OWNER}},
    '{OP_REQUEST, 4'd10, 4'd12, 1'b0, '0}
  };

  // pool size per random phase, from tight contention up to the full id range
  int phase_pool[NUM_PHASES] = '{2, 3, 4, 5, 6, 8, 16};

  // event side: directed table, then random phases, then the drain
  initial begin
    for (int i = 0; i < N_LOCKS; i++) begin
      lock_held[i] = 1'b0;
      lock_holder[i] = '0;
    end
    for (int i = 0; i < N_PROCS; i++) begin
      proc_blocked[i] = 1'b0;
      proc_waits_on[i] = '0;
    end
    evt_ch.valid <= 1'b0;
    evt_ch.opcode <= '0;
    evt_ch.process_id <= '0;
    evt_ch.lock_id <= '0;
    @(negedge clk);
    while (rst) @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) send_event(directed_rows[i]);
    // let the whole directed part come back before random traffic
    hold_until_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      int base;
      base = $urandom_range(0, 15);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_event(random_event(phase_pool[ph], base));
      hold_until_drained();
    end

    // all stimulus is in; wait out anything still on its way
    evt_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d events, %0d requests, %0d verdicts checked", n_events, n_requests,
             n_verdicts);
    $display("tb_top: %0d deadlocks, %0d walk limits, %0d requests on free locks", n_deadlocks,
             n_limit_hits, n_unowned);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // result side: random back-pressure, each verdict checked against the oldest owed one
  initial begin
    int stall;
    verdict_t want;
    res_ch.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
      stall = draw_gap(recv_burst);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      n_verdicts++;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected verdict deadlock=%0b steps=%0d status=%0d", $time,
                 res_ch.deadlock, res_ch.chain_steps, res_ch.status);
      end else begin
        want = pending_verdicts.pop_front();
        if (res_ch.deadlock !== want.deadlock) begin
          errors++;
          $display("%0t: deadlock expected %0b got %0b", $time, want.deadlock,
                   res_ch.deadlock);
        end
        if (res_ch.chain_steps !== want.chain_steps) begin
          errors++;
          $display("%0t: chain_steps expected %0d got %0d", $time, want.chain_steps,
                   res_ch.chain_steps);
        end
        if (res_ch.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, res_ch.status);
        end
      end
      @(negedge clk);
    end
  end

  // watchdog: too many cycles without any transaction on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d verdicts still owed", $time,
                 STALL_LIMIT, pending_verdicts.size());
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

endmodule

@@ wait_for_chain_deadlock_detector.f @@
+incdir+rtl
rtl/wfcdd_pkg.sv
rtl/wfcdd_evt_if.sv
rtl/wfcdd_res_if.sv
rtl/wfcdd_ram.sv
rtl/wfcdd_seq.sv
rtl/wfcdd_dp.sv
rtl/wait_for_chain_deadlock_detector.sv
test/tb_top.sv
